[hw/rtl/command_frame_receiver_core_assert.svh]
// ----------------------------------------------------------------------------
// Command frame receiver assertion macros
// Concurrent assertion wrappers shared by the receiver modules. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CFRX_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfrx assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define CFRX_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfrx assertion failed");
`else
`define CFRX_ASSERT_IMP(label, ante, cons)
`define CFRX_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hw/rtl/cfrx_pkg.sv]
// ----------------------------------------------------------------------------
// Command frame receiver package
// Sizes, result kind codes, register indexes and the frame event type.
// ----------------------------------------------------------------------------
package cfrx_pkg;

   // Number of bytes one frame may store, checksum included.
   localparam int FRAME_DEPTH = 10;
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
   localparam int IDX_W       = $clog2(FRAME_DEPTH);

   localparam logic [CNT_W-1:0] FRAME_DEPTH_CNT = CNT_W'(FRAME_DEPTH);

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = CSR_IDX_W'(1);

   localparam logic [7:0] START_BYTE_RST = 8'd58;
   localparam logic [7:0] END_BYTE_RST   = 8'd13;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_CSUM_ERR = 2'd1,
      KIND_OVF_ERR  = 2'd2
   } kind_type;

   // What the frame parser asks of the buffer for one accepted byte.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [7:0]       wr_data;
      logic             err_load;
      kind_type         err_kind;
      logic [7:0]       err_byte;
      logic             replay_start;
      logic [IDX_W-1:0] replay_last;
   } frame_evt_type;

endpackage

[hw/rtl/command_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// Command frame receiver core
// Receives serial bytes, frames them between a start byte and an end byte,
// checks a negated-sum checksum and replays the payload of good frames.
//
// The receiver takes one byte per clock cycle. Bytes outside a frame are
// dropped until the start byte arrives; inside a frame every byte other than
// the end byte is stored, up to ten bytes including the checksum. When the
// end byte arrives the frame is closed: a good frame, whose stored bytes sum
// to zero modulo 256, is replayed as N payload transactions (the checksum is
// not sent), the last one flagged with rsp_last. A frame that overflowed the
// store gives one transaction of kind 2, and an empty frame, a frame holding
// only a checksum, or a bad checksum gives one transaction of kind 1; these
// carry the frame's first stored byte (zero for an empty frame). Replay reads
// the frame store at one byte per cycle while the result side does not stall,
// and after the end byte of a good frame the input is held off until its whole
// payload has been replayed. The end byte is also held off while an earlier
// result still waits in the output register; all other bytes keep flowing.
// Start and end bytes are programmed through the csr port (index 0 start byte,
// reset ':', index 1 end byte, reset carriage return) and should only be
// changed while no frame is in progress.
// ----------------------------------------------------------------------------

module command_frame_receiver_core (
   input  logic                           clock,
   input  logic                           reset,
   // Received bytes.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   // Frame results.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_payload,
   output logic                           rsp_last,
   // Register writes.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cfrx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import cfrx_pkg::*;

   logic [7:0]    start_byte_ff, start_byte_in;
   logic [7:0]    end_byte_ff, end_byte_in;
   logic          accept;
   logic          in_frame;
   logic          replay_busy;
   frame_evt_type evt;

   // The register file is always ready; a write to an unknown index is
   // accepted and ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_START_BYTE) begin
            start_byte_in = csr_wdata;
         end else if (csr_index == CSR_END_BYTE) begin
            end_byte_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         end_byte_ff   <= END_BYTE_RST;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
      end
   end

   // Input is held while a payload replay owns the frame store and the
   // output register, and an end byte, which produces a result at once, is
   // held while the output register is still full and stalled.
   assign req_stall = replay_busy
                      || (rsp_valid && rsp_stall && in_frame
                          && req_rx_byte == end_byte_ff);
   assign accept    = req_valid && !req_stall;

   cfrx_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .start_byte (start_byte_ff),
      .end_byte   (end_byte_ff),
      .in_frame   (in_frame),
      .evt        (evt)
   );

   cfrx_replay u_replay (
      .clock       (clock),
      .reset       (reset),
      .evt         (evt),
      .rsp_stall   (rsp_stall),
      .busy        (replay_busy),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_payload (rsp_payload),
      .rsp_last    (rsp_last)
   );

endmodule

[hw/rtl/cfrx_parse.sv]
// ----------------------------------------------------------------------------
// Command frame parser
// Tracks frame state, byte count, overflow and running sum, and decides the
// outcome of a frame when its end byte arrives.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_core_assert.svh"

module cfrx_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            start_byte,
   input  logic [7:0]            end_byte,
   output logic                  in_frame,
   output cfrx_pkg::frame_evt_type evt
);
   import cfrx_pkg::*;

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       first_ff, first_in;
   logic [CNT_W-1:0] cnt_m2;

   assign cnt_m2   = cnt_ff - CNT_W'(2);
   assign in_frame = in_frame_ff;

   // The checksum byte is right when all stored bytes, checksum included,
   // sum to zero, so one running sum is enough.
   always_comb begin
      in_frame_in = in_frame_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      sum_in      = sum_ff;
      first_in    = first_ff;

      evt              = '0;
      evt.wr_idx       = cnt_ff[IDX_W-1:0];
      evt.wr_data      = rx_byte;
      evt.err_kind     = KIND_CSUM_ERR;
      evt.err_byte     = first_ff;
      evt.replay_last  = cnt_m2[IDX_W-1:0];

      if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == start_byte) begin
               in_frame_in = 1'b1;
               cnt_in      = '0;
               ovf_in      = 1'b0;
               sum_in      = '0;
            end
         end else if (rx_byte != end_byte) begin
            if (cnt_ff < FRAME_DEPTH_CNT) begin
               evt.wr_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
               sum_in    = sum_ff + rx_byte;
               if (cnt_ff == '0) begin
                  first_in = rx_byte;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end else begin
            in_frame_in = 1'b0;
            cnt_in      = '0;
            ovf_in      = 1'b0;
            priority if (ovf_ff) begin
               evt.err_load = 1'b1;
               evt.err_kind = KIND_OVF_ERR;
            end else if (cnt_ff == '0) begin
               evt.err_load = 1'b1;
               evt.err_byte = 8'h00;
            end else if (cnt_ff == CNT_W'(1) || sum_ff != 8'h00) begin
               evt.err_load = 1'b1;
            end else begin
               evt.replay_start = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      first_ff <= first_in;
   end

   `CFRX_ASSERT_IMP(a_count_bounded, 1'b1, cnt_ff <= FRAME_DEPTH_CNT)
   `CFRX_ASSERT_NXT(a_idle_after_close, evt.err_load || evt.replay_start,
                    !in_frame_ff && cnt_ff == '0)

endmodule

[hw/rtl/cfrx_replay.sv]
// ----------------------------------------------------------------------------
// Command frame buffer and replay
// Holds the stored bytes of the open frame and drives the result register,
// replaying a good frame's payload one byte per cycle unless the result stalls.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_core_assert.svh"

module cfrx_replay (
   input  logic                    clock,
   input  logic                    reset,
   input  cfrx_pkg::frame_evt_type evt,
   input  logic                    rsp_stall,
   output logic                    busy,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_payload,
   output logic                    rsp_last
);
   import cfrx_pkg::*;

   logic [7:0] store_mem [FRAME_DEPTH];

   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [7:0]       rsp_payload_ff;
   logic             out_free;
   logic             load_rep;
   logic             rep_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rep = active_ff && out_free;
   assign rep_done = idx_ff == last_idx_ff;

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      if (evt.replay_start) begin
         active_in   = 1'b1;
         idx_in      = '0;
         last_idx_in = evt.replay_last;
      end

      if (load_rep) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_DATA;
         rsp_last_in  = rep_done;
         idx_in       = idx_ff + IDX_W'(1);
         if (rep_done) begin
            active_in = 1'b0;
         end
      end else if (evt.err_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = evt.err_kind;
         rsp_last_in  = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Frame store: one write port from the parser, one registered read port
   // that lands straight in the result payload register.
   always_ff @(posedge clock) begin
      if (evt.wr_en) begin
         store_mem[evt.wr_idx] <= evt.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rep) begin
         rsp_payload_ff <= store_mem[idx_ff];
      end else if (evt.err_load) begin
         rsp_payload_ff <= evt.err_byte;
      end
   end

   assign busy        = active_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_last    = rsp_last_ff;

   `CFRX_ASSERT_IMP(a_no_event_in_replay, active_ff,
                    !evt.err_load && !evt.replay_start && !evt.wr_en)
   `CFRX_ASSERT_IMP(a_err_needs_room, evt.err_load, out_free)
   `CFRX_ASSERT_IMP(a_idx_in_range, active_ff, idx_ff <= last_idx_ff)

endmodule
